// ----- sv/oale_pkg.sv -----
// Package for the ordered array list engine: opcodes, status codes,
// default capacity and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package oale_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam logic [2:0] OP_SEARCH = 3'd0;
    localparam logic [2:0] OP_COUNT  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;
    localparam logic [2:0] OP_APPEND = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_POS   = 2'd2;
    localparam logic [1:0] ST_NO_ROOM   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // an input transfer happens this cycle
        logic step;     // one scan step of a search or count
    } oale_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_scan;  // accepted item is a search or count over a nonempty list
        logic scan_done;   // current scan step produces the result
    } oale_stat_t;

endpackage

`default_nettype wire

// ----- sv/oale_ctrl.sv -----
// Controller of the ordered array list engine: idle/scan state machine and
// result-valid flag. Depends on oale_pkg.
`default_nettype none

module oale_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire oale_pkg::oale_stat_t stat,
    output oale_pkg::oale_cmd_t     cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready       = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
        cmd.accept     = in_valid && in_ready;
        cmd.step       = (state_reg == S_SCAN);
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    if (stat.needs_scan)
                        state_next = S_SCAN;
                    else
                        out_valid_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- sv/oale_dp.sv -----
// Datapath of the ordered array list engine: entry cells with shift logic,
// fill count, run flag, scan counter and result registers. Depends on oale_pkg.
`default_nettype none

module oale_dp #(
    parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire oale_pkg::oale_cmd_t  cmd,
    output oale_pkg::oale_stat_t      stat,
    input  wire logic [2:0]           opcode,
    input  wire logic [5:0]           position,
    input  wire logic signed [31:0]   value,
    input  wire logic                 first_of_run,
    input  wire logic [5:0]           run_length,
    output logic signed [31:0]        data,
    output logic [4:0]                index,
    output logic [1:0]                status,
    output logic [5:0]                fill_level,
    output logic                      is_full,
    output logic                      is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PX = ((CW > 6) ? CW : 6) + 1;
    localparam logic [PX-1:0] CAP_X = PX'(CAPACITY);

    logic signed [31:0] entries_reg [CAPACITY];
    logic [CW-1:0]      fill_reg, fill_new;
    logic               run_reg, run_new;
    logic [CW-1:0]      scan_idx_reg;
    logic [CW-1:0]      acc_reg;
    logic signed [31:0] val_reg;
    logic               is_search_reg;

    logic signed [31:0] data_reg, res_data;
    logic [4:0]         index_reg, res_index;
    logic [1:0]         status_reg, res_status;
    logic [5:0]         fill_level_reg;
    logic               full_reg, empty_reg;

    logic [PX-1:0]      pos_x, fill_x, need_x;
    logic [IW-1:0]      rd_addr;
    logic signed [31:0] rd_word;
    logic               match, scan_last;
    logic               ins_en, rem_en, app_en, load_out;
    logic [CW-1:0]      acc_sum;

    assign pos_x   = PX'(position);
    assign fill_x  = PX'(fill_reg);
    assign need_x  = (run_length == 6'd0) ? PX'(1) : PX'(run_length);
    assign rd_addr = cmd.step ? scan_idx_reg[IW-1:0] : pos_x[IW-1:0];
    assign rd_word = entries_reg[rd_addr];

    assign match     = (rd_word == val_reg);
    assign scan_last = ((scan_idx_reg + CW'(1)) == fill_reg);
    assign acc_sum   = acc_reg + CW'(match);

    assign stat.needs_scan = ((opcode == oale_pkg::OP_SEARCH) ||
                              (opcode == oale_pkg::OP_COUNT)) && (fill_reg != '0);
    assign stat.scan_done  = (is_search_reg && match) || scan_last;

    always_comb
    begin
        res_data   = '0;
        res_index  = '0;
        res_status = oale_pkg::ST_OK;
        fill_new   = fill_reg;
        run_new    = run_reg;
        ins_en     = 1'b0;
        rem_en     = 1'b0;
        app_en     = 1'b0;
        if (cmd.step)
        begin
            if (is_search_reg)
            begin
                if (match)
                    res_index = 5'(scan_idx_reg);
                else
                    res_status = oale_pkg::ST_NOT_FOUND;
            end
            else
            begin
                res_data = 32'(acc_sum);
            end
        end
        else
        begin
            if ((opcode != oale_pkg::OP_APPEND) && (opcode != oale_pkg::OP_UNUSED))
                run_new = 1'b0;
            case (opcode)
                oale_pkg::OP_SEARCH: res_status = oale_pkg::ST_NOT_FOUND;
                oale_pkg::OP_COUNT:  res_data = '0;
                oale_pkg::OP_READ:
                begin
                    if (pos_x < fill_x)
                        res_data = rd_word;
                    else
                        res_status = oale_pkg::ST_BAD_POS;
                end
                oale_pkg::OP_INSERT:
                begin
                    if (pos_x > fill_x)
                        res_status = oale_pkg::ST_BAD_POS;
                    else if (fill_x >= CAP_X)
                        res_status = oale_pkg::ST_NO_ROOM;
                    else
                    begin
                        ins_en   = 1'b1;
                        fill_new = fill_reg + CW'(1);
                    end
                end
                oale_pkg::OP_REMOVE:
                begin
                    if (pos_x < fill_x)
                    begin
                        res_data = rd_word;
                        rem_en   = 1'b1;
                        fill_new = fill_reg - CW'(1);
                    end
                    else
                        res_status = oale_pkg::ST_BAD_POS;
                end
                oale_pkg::OP_APPEND:
                begin
                    if (first_of_run)
                    begin
                        if ((fill_x + need_x) <= CAP_X)
                        begin
                            run_new  = 1'b1;
                            app_en   = 1'b1;
                            fill_new = fill_reg + CW'(1);
                        end
                        else
                        begin
                            run_new    = 1'b0;
                            res_status = oale_pkg::ST_NO_ROOM;
                        end
                    end
                    else if (run_reg && (fill_x < CAP_X))
                    begin
                        app_en   = 1'b1;
                        fill_new = fill_reg + CW'(1);
                    end
                    else
                    begin
                        run_new    = 1'b0;
                        res_status = oale_pkg::ST_NO_ROOM;
                    end
                end
                oale_pkg::OP_CLEAR: fill_new = '0;
                default: res_status = oale_pkg::ST_OK;
            endcase
            ins_en = ins_en && cmd.accept;
            rem_en = rem_en && cmd.accept;
            app_en = app_en && cmd.accept;
        end
    end

    assign load_out = (cmd.accept && !stat.needs_scan) || (cmd.step && stat.scan_done);

    // Each cell looks only at its own neighbors, so insert and remove shift all cells at once.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        localparam logic [PX-1:0] GI = PX'(g);
        logic signed [31:0] below_word, above_word;
        if (g > 0)
        begin : g_below
            assign below_word = entries_reg[g-1];
        end
        else
        begin : g_no_below
            assign below_word = value;
        end
        if (g < CAPACITY - 1)
        begin : g_above
            assign above_word = entries_reg[g+1];
        end
        else
        begin : g_no_above
            assign above_word = entries_reg[g];
        end
        always_ff @(posedge clk)
        begin
            if (ins_en)
            begin
                if (GI == pos_x)
                    entries_reg[g] <= value;
                else if ((GI > pos_x) && (GI <= fill_x))
                    entries_reg[g] <= below_word;
            end
            else if (rem_en)
            begin
                if ((GI >= pos_x) && ((GI + PX'(1)) < fill_x))
                    entries_reg[g] <= above_word;
            end
            else if (app_en)
            begin
                if (GI == fill_x)
                    entries_reg[g] <= value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            run_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            fill_reg <= fill_new;
            run_reg  <= run_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            scan_idx_reg  <= '0;
            acc_reg       <= '0;
            val_reg       <= value;
            is_search_reg <= (opcode == oale_pkg::OP_SEARCH);
        end
        else if (cmd.step)
        begin
            scan_idx_reg <= scan_idx_reg + CW'(1);
            acc_reg      <= acc_sum;
        end
        if (load_out)
        begin
            data_reg       <= res_data;
            index_reg      <= res_index;
            status_reg     <= res_status;
            fill_level_reg <= 6'(fill_new);
            full_reg       <= (fill_new == CW'(CAPACITY));
            empty_reg      <= (fill_new == '0);
        end
    end

    assign data       = data_reg;
    assign index      = index_reg;
    assign status     = status_reg;
    assign fill_level = fill_level_reg;
    assign is_full    = full_reg;
    assign is_empty   = empty_reg;

endmodule

`default_nettype wire

// ----- sv/ordered_array_list_engine.sv -----
// Ordered array list engine: bounded ordered list of signed words with search,
// count, read, insert, remove, append runs and clear.
// Depends on oale_pkg, oale_ctrl and oale_dp.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one operation per transfer:
//   opcode, position, value, first_of_run and run_length. The output channel
//   (out_valid/out_ready) returns exactly one result per operation: data,
//   index, status, fill_level, is_full and is_empty.
//   Read, insert, remove, append, clear and the unused opcode finish in the
//   cycle they are accepted; the result is valid in the cycle after the transfer.
//   Search and count walk the filled part of the list one entry per cycle
//   through a single compare unit (search stops at the first match); the
//   result is then loaded into the output register.
//   An empty list answers search and count at once.
//   The block works on one operation at a time. A new item is accepted while
//   the previous result is being taken in the same cycle; if the receiver
//   stalls, the result is held in the output register and in_ready stays low.
//   Reset empties the list and ends any append run; entry contents are not
//   cleared, since only entries below the fill count are ever read.
`default_nettype none

module ordered_array_list_engine #(
    parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         opcode,
    input  wire logic [5:0]         position,
    input  wire logic signed [31:0] value,
    input  wire logic               first_of_run,
    input  wire logic [5:0]         run_length,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      data,
    output logic [4:0]              index,
    output logic [1:0]              status,
    output logic [5:0]              fill_level,
    output logic                    is_full,
    output logic                    is_empty
);

    oale_pkg::oale_cmd_t  cmd;
    oale_pkg::oale_stat_t stat;

    // The controller owns the handshake and the scan sequencing.
    oale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the list cells, counters and result registers.
    oale_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .position     (position),
        .value        (value),
        .first_of_run (first_of_run),
        .run_length   (run_length),
        .data         (data),
        .index        (index),
        .status       (status),
        .fill_level   (fill_level),
        .is_full      (is_full),
        .is_empty     (is_empty)
    );

endmodule

`default_nettype wire

// ----- tb/tb_ordered_array_list_engine.sv -----
// Self-checking testbench for ordered_array_list_engine: directed and random list operations
// checked against a cycle-free shadow of the list kept in a small scoreboard class.
// Depends on oale_pkg and the ordered_array_list_engine RTL.
`timescale 1ns / 100ps

module tb_ordered_array_list_engine;

    localparam int LIST_DEPTH = oale_pkg::CAPACITY_DEF;

    // A result may need a full scan of the list plus the output register.
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

    // Cycles without any transfer before the run is declared hung. The slowest
    // legal gap is the receiver hold below plus a full scan and both idle draws.
    localparam int WATCHDOG_LIMIT = 2000;

    // Long receiver hold used to back the block up and stall its input.
    localparam int HOLD_CYCLES = 150;

    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [5:0]         position;
        logic signed [31:0] value;
        logic               first_of_run;
        logic [5:0]         run_length;
    } list_op_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [4:0]         index;
        logic [1:0]         status;
        logic [5:0]         fill_level;
        logic               is_full;
        logic               is_empty;
    } list_result_t;

    // Shadow copy of the list. Every accepted operation is applied to the
    // shadow right away and the result it must produce is queued; results
    // leave the block in order, so each one is checked against the oldest.
    class list_shadow_t;
        logic signed [31:0] words [LIST_DEPTH];
        int                 fill;
        bit                 run_open;
        list_result_t       due_results [$];
        int                 error_count;

        function new();
            foreach (words[i])
            begin
                words[i] = '0;
            end
            fill        = 0;
            run_open    = 1'b0;
            error_count = 0;
        endfunction

        // Applies one operation to the shadow list and returns its result.
        function list_result_t apply_op(list_op_t op);
            list_result_t res;
            int           pos;
            int           need;
            bit           found;

            res        = '0;
            res.status = oale_pkg::ST_OK;
            pos        = int'(op.position);
            found      = 1'b0;

            // Anything but an append (or the unused opcode) ends an append run.
            if (op.opcode != oale_pkg::OP_APPEND && op.opcode != oale_pkg::OP_UNUSED)
            begin
                run_open = 1'b0;
            end

            case (op.opcode)
                oale_pkg::OP_SEARCH:
                begin
                    res.status = oale_pkg::ST_NOT_FOUND;
                    for (int i = 0; i < fill; i++)
                    begin
                        if (!found && words[i] == op.value)
                        begin
                            found      = 1'b1;
                            res.index  = 5'(i);
                            res.status = oale_pkg::ST_OK;
                        end
                    end
                end
                oale_pkg::OP_COUNT:
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        if (words[i] == op.value)
                        begin
                            res.data = res.data + 32'sd1;
                        end
                    end
                end
                oale_pkg::OP_READ:
                begin
                    if (pos < fill)
                    begin
                        res.data = words[pos];
                    end
                    else
                    begin
                        res.status = oale_pkg::ST_BAD_POS;
                    end
                end
                oale_pkg::OP_INSERT:
                begin
                    if (pos > fill)
                    begin
                        res.status = oale_pkg::ST_BAD_POS;
                    end
                    else if (fill >= LIST_DEPTH)
                    begin
                        res.status = oale_pkg::ST_NO_ROOM;
                    end
                    else
                    begin
                        for (int i = fill; i > pos; i--)
                        begin
                            words[i] = words[i - 1];
                        end
                        words[pos] = op.value;
                        fill++;
                    end
                end
                oale_pkg::OP_REMOVE:
                begin
                    if (pos < fill)
                    begin
                        res.data = words[pos];
                        for (int i = pos; i + 1 < fill; i++)
                        begin
                            words[i] = words[i + 1];
                        end
                        fill--;
                    end
                    else
                    begin
                        res.status = oale_pkg::ST_BAD_POS;
                    end
                end
                oale_pkg::OP_APPEND:
                begin
                    if (op.first_of_run)
                    begin
                        need = (op.run_length == 6'd0) ? 1 : int'(op.run_length);
                        if (fill + need <= LIST_DEPTH)
                        begin
                            run_open    = 1'b1;
                            words[fill] = op.value;
                            fill++;
                        end
                        else
                        begin
                            run_open   = 1'b0;
                            res.status = oale_pkg::ST_NO_ROOM;
                        end
                    end
                    else if (run_open && fill < LIST_DEPTH)
                    begin
                        words[fill] = op.value;
                        fill++;
                    end
                    else
                    begin
                        run_open   = 1'b0;
                        res.status = oale_pkg::ST_NO_ROOM;
                    end
                end
                oale_pkg::OP_CLEAR:
                begin
                    fill = 0;
                end
                default:
                begin
                end
            endcase

            res.fill_level = 6'(fill);
            res.is_full    = (fill == LIST_DEPTH);
            res.is_empty   = (fill == 0);
            return res;
        endfunction

        function void note_op(list_op_t op);
            due_results.push_back(apply_op(op));
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            bit           bad;

            if (due_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: result with nothing outstanding: data=%0d index=%0d status=%0d",
                             $realtime, got.data, got.index, got.status);
                end
                return;
            end
            want = due_results.pop_front();
            bad  = (got.data !== want.data) || (got.index !== want.index) ||
                   (got.status !== want.status) || (got.fill_level !== want.fill_level) ||
                   (got.is_full !== want.is_full) || (got.is_empty !== want.is_empty);
            if (bad)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch data %0d/%0d index %0d/%0d status %0d/%0d",
                             $realtime, want.data, got.data, want.index, got.index,
                             want.status, got.status);
                    $display("    fill %0d/%0d full %0b/%0b empty %0b/%0b (expected/actual)",
                             want.fill_level, got.fill_level, want.is_full, got.is_full,
                             want.is_empty, got.is_empty);
                end
            end
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [2:0]         opcode       = oale_pkg::OP_SEARCH;
    logic [5:0]         position     = '0;
    logic signed [31:0] value        = '0;
    logic               first_of_run = 1'b0;
    logic [5:0]         run_length   = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic signed [31:0] data;
    logic [4:0]         index;
    logic [1:0]         status;
    logic [5:0]         fill_level;
    logic               is_full;
    logic               is_empty;

    list_shadow_t shadow = new();

    int  ops_sent      = 0;
    bit  sender_steady = 1'b0;  // when set, the sender offers items back to back

    ordered_array_list_engine #(
        .CAPACITY(LIST_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .position    (position),
        .value       (value),
        .first_of_run(first_of_run),
        .run_length  (run_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data        (data),
        .index       (index),
        .status      (status),
        .fill_level  (fill_level),
        .is_full     (is_full),
        .is_empty    (is_empty)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Both channels are sampled at the rising edge, before any of this edge's
    // nonblocking updates land. The result is checked before the new input is
    // noted so that a transfer on each side in the same cycle is ordered right.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                shadow.check_result('{data, index, status, fill_level, is_full, is_empty});
            end
            if (in_valid && in_ready)
            begin
                shadow.note_op('{opcode, position, value, first_of_run, run_length});
            end
        end
    end

    // Watchdog: any cycle with a transfer on either side, or with reset held, restarts the count.
    initial
    begin : watchdog
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver. Stalls are drawn per result; every hundred results it may switch
    // to a stretch with no stalls at all. Twice during the run it holds off for
    // a long stretch so the block backs up and drops in_ready.
    initial
    begin : receiver
        int  taken;
        int  stall;
        bit  steady;

        taken  = 0;
        steady = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 100 == 0)
            begin
                steady = ($urandom_range(0, 2) == 0);
            end
            if (taken == 300 || taken == 800)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = steady ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            taken++;
        end
    end

    function automatic list_op_t make_op(logic [2:0] op, int pos, logic signed [31:0] word,
                                         logic first, int len);
        list_op_t item;

        item.opcode       = op;
        item.position     = 6'(pos);
        item.value        = word;
        item.first_of_run = first;
        item.run_length   = 6'(len);
        return item;
    endfunction

    // Values lean toward a small set so that searches and counts hit often,
    // with the signed extremes, words already in the list and full-range words mixed in.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            1, 2:    return 32'($urandom_range(0, 7)) - 32'sd3;
            3:
            begin
                if (shadow.fill > 0)
                begin
                    return shadow.words[$urandom_range(0, shadow.fill - 1)];
                end
                return 32'($urandom);
            end
            default: return 32'($urandom);
        endcase
    endfunction

    // Mostly a legal position up to span; now and then anything the field allows.
    function automatic int pick_pos(int span);
        if (span >= 0 && $urandom_range(0, 4) != 0)
        begin
            return $urandom_range(0, span);
        end
        return $urandom_range(0, 63);
    endfunction

    // Offers one item and returns once it has been transferred. in_valid is
    // lowered only when an idle gap follows, so back-to-back items never see
    // it dropped and raised within one time step.
    task automatic send_op(list_op_t item);
        int gap;

        gap = sender_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= item.opcode;
        position     <= item.position;
        value        <= item.value;
        first_of_run <= item.first_of_run;
        run_length   <= item.run_length;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        ops_sent++;
    endtask

    // An append run: the head carries the length, the body follows with
    // first_of_run low. Most runs are well formed; some are cut short, some
    // overrun their length, and some are too long to fit at all.
    task automatic send_append_run();
        int len;
        int body;

        case ($urandom_range(0, 9))
            0:       len = $urandom_range(0, 63);
            1:       len = (shadow.fill < LIST_DEPTH) ? LIST_DEPTH - shadow.fill : 1;
            2:       len = LIST_DEPTH - shadow.fill + 1;
            default: len = $urandom_range(1, 6);
        endcase
        send_op(make_op(oale_pkg::OP_APPEND, $urandom_range(0, 63), pick_word(), 1'b1, len));
        body = ((len == 0) ? 1 : len) - 1;
        case ($urandom_range(0, 9))
            0:       body = (body > 0) ? $urandom_range(0, body - 1) : 0;
            1:       body = body + $urandom_range(1, 3);
            default: ;
        endcase
        repeat (body)
        begin
            send_op(make_op(oale_pkg::OP_APPEND, $urandom_range(0, 63), pick_word(), 1'b0,
                            $urandom_range(0, 63)));
        end
    endtask

    // One random operation or run, weighted toward growing the list so that
    // the full-list cases come up regularly.
    task automatic send_random_op();
        int               pick;
        int               pos_any;
        logic             first_any;
        int               len_any;

        pick      = $urandom_range(0, 99);
        pos_any   = $urandom_range(0, 63);
        first_any = 1'($urandom_range(0, 1));
        len_any   = $urandom_range(0, 63);
        if (pick < 25)
        begin
            send_append_run();
        end
        else if (pick < 45)
        begin
            send_op(make_op(oale_pkg::OP_INSERT, pick_pos(shadow.fill), pick_word(), first_any,
                            len_any));
        end
        else if (pick < 60)
        begin
            send_op(make_op(oale_pkg::OP_REMOVE, pick_pos(shadow.fill - 1), pick_word(),
                            first_any, len_any));
        end
        else if (pick < 70)
        begin
            send_op(make_op(oale_pkg::OP_READ, pick_pos(shadow.fill - 1), pick_word(),
                            first_any, len_any));
        end
        else if (pick < 80)
        begin
            send_op(make_op(oale_pkg::OP_SEARCH, pos_any, pick_word(), first_any, len_any));
        end
        else if (pick < 90)
        begin
            send_op(make_op(oale_pkg::OP_COUNT, pos_any, pick_word(), first_any, len_any));
        end
        else if (pick < 93)
        begin
            send_op(make_op(oale_pkg::OP_CLEAR, pos_any, pick_word(), first_any, len_any));
        end
        else if (pick < 96)
        begin
            send_op(make_op(oale_pkg::OP_UNUSED, pos_any, pick_word(), first_any, len_any));
        end
        else
        begin
            // Stray run body with no head in front of it.
            send_op(make_op(oale_pkg::OP_APPEND, pos_any, pick_word(), 1'b0, len_any));
        end
    endtask

    initial
    begin : stimulus
        int random_start;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: search, count, read, remove and insert on an empty list, the
        // position checks at both ends, the signed extremes, a zero-length run head, a
        // run whose body overruns its length, a run that cannot fit, and the unused opcode.
        send_op(make_op(oale_pkg::OP_SEARCH, 0, 32'sd0, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_COUNT, 0, 32'sd0, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_READ, 0, 32'sd0, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_REMOVE, 0, 32'sd0, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_INSERT, 1, 32'sd5, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_INSERT, 0, 32'sh7fff_ffff, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_INSERT, 0, 32'sh8000_0000, 1'b1, 63));
        send_op(make_op(oale_pkg::OP_INSERT, 2, -32'sd1, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_SEARCH, 63, -32'sd1, 1'b1, 63));
        send_op(make_op(oale_pkg::OP_COUNT, 0, 32'sh8000_0000, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_READ, 1, 32'sd0, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_READ, 3, 32'sd0, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_REMOVE, 0, 32'sd0, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_UNUSED, 63, -32'sd1, 1'b1, 63));
        send_op(make_op(oale_pkg::OP_APPEND, 0, 32'sd7, 1'b1, 0));
        send_op(make_op(oale_pkg::OP_APPEND, 0, 32'sd7, 1'b1, 3));
        send_op(make_op(oale_pkg::OP_APPEND, 0, 32'sd8, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_APPEND, 0, 32'sd9, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_APPEND, 0, 32'sd10, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_COUNT, 0, 32'sd7, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_APPEND, 0, 32'sd1, 1'b1, 63));
        send_op(make_op(oale_pkg::OP_APPEND, 0, 32'sd2, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_CLEAR, 0, 32'sd0, 1'b0, 0));
        send_op(make_op(oale_pkg::OP_INSERT, 63, 32'sd0, 1'b0, 0));

        // Random part. The sender's idling style changes every hundred items.
        random_start = ops_sent;
        while (ops_sent - random_start < RANDOM_ITEMS)
        begin
            if ((ops_sent - random_start) % 100 < 3)
            begin
                sender_steady = ($urandom_range(0, 2) == 0);
            end
            send_random_op();
        end
        in_valid <= 1'b0;

        // Drain: wait for every expected result, then give a scan's worth of
        // cycles for anything extra to show up.
        while (shadow.due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.error_count == 0 && shadow.due_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/oale_pkg.sv
sv/oale_ctrl.sv
sv/oale_dp.sv
sv/ordered_array_list_engine.sv
tb/tb_ordered_array_list_engine.sv
